// ===== rtl/lsu_pkg.sv =====
// Shared types, codes and helper functions of the x86 logic and shift unit.
package lsu_pkg;

    localparam int DataW = 32;
    localparam int CntW  = 5;
    localparam int BitsW = 6;

    typedef enum logic [3:0] {
        CMD_AND   = 4'd0,
        CMD_OR    = 4'd1,
        CMD_XOR   = 4'd2,
        CMD_TEST  = 4'd3,
        CMD_NOT   = 4'd4,
        CMD_SHL   = 4'd5,
        CMD_SHR   = 4'd6,
        CMD_SAR   = 4'd7,
        CMD_ROL   = 4'd8,
        CMD_SETCC = 4'd9
    } lsu_cmd_t;

    typedef enum logic [1:0] {
        W_BYTE  = 2'd0,
        W_WORD  = 2'd1,
        W_DWORD = 2'd2
    } lsu_width_t;

    // condition pair, i.e. cond_code with the negate bit dropped
    typedef enum logic [2:0] {
        CC_O  = 3'd0,
        CC_B  = 3'd1,
        CC_E  = 3'd2,
        CC_BE = 3'd3,
        CC_S  = 3'd4,
        CC_P  = 3'd5,
        CC_L  = 3'd6,
        CC_LE = 3'd7
    } lsu_cc_t;

    typedef struct packed {
        logic cf;
        logic zf;
        logic sf;
        logic of;
    } lsu_flags_t;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [1:0]       wsel;
        logic [DataW-1:0] mask;
        logic [DataW-1:0] d;
        logic [DataW-1:0] s;
        logic [CntW-1:0]  cnt;
        logic [CntW-1:0]  rot;
        logic             cond;
        lsu_flags_t       flags;
    } lsu_dec_t;

    typedef struct packed {
        logic [DataW-1:0] r;
        logic             wb;
        logic             setzs;
        logic             clrco;
        logic [1:0]       wsel;
        lsu_flags_t       flags;
    } lsu_exe_t;

    function automatic logic [DataW-1:0] width_mask(input logic [1:0] wsel);
        logic [DataW-1:0] m;
        case (wsel)
            W_BYTE:  m = 32'h0000_00ff;
            W_WORD:  m = 32'h0000_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [BitsW-1:0] width_bits(input logic [1:0] wsel);
        logic [BitsW-1:0] b;
        case (wsel)
            W_BYTE:  b = 6'd8;
            W_WORD:  b = 6'd16;
            default: b = 6'd32;
        endcase
        return b;
    endfunction

    function automatic logic sign_bit(input logic [DataW-1:0] v, input logic [1:0] wsel);
        logic sb;
        case (wsel)
            W_BYTE:  sb = v[7];
            W_WORD:  sb = v[15];
            default: sb = v[31];
        endcase
        return sb;
    endfunction

endpackage

// ===== rtl/lsu_decode.sv =====
// First stage: operand masking, count preparation and condition evaluation.
module lsu_decode
    import lsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [3:0]       cmd,
    input  logic [1:0]       width_code,
    input  logic [DataW-1:0] dest_value,
    input  logic [DataW-1:0] src_value,
    input  logic [3:0]       cond_code,
    input  lsu_flags_t       flags_in,
    input  logic             parity_in,
    output logic             dec_valid,
    output lsu_dec_t         dec
);

    logic     valid_reg;
    lsu_dec_t dec_reg;
    lsu_dec_t dec_next;
    logic     cond_raw;

    always_comb
    begin
        case (lsu_cc_t'(cond_code[3:1]))
            CC_O:    cond_raw = flags_in.of;
            CC_B:    cond_raw = flags_in.cf;
            CC_E:    cond_raw = flags_in.zf;
            CC_BE:   cond_raw = flags_in.cf | flags_in.zf;
            CC_S:    cond_raw = flags_in.sf;
            CC_P:    cond_raw = parity_in;
            CC_L:    cond_raw = flags_in.sf ^ flags_in.of;
            default: cond_raw = flags_in.zf | (flags_in.sf ^ flags_in.of);
        endcase
    end

    always_comb
    begin
        dec_next.cmd   = cmd;
        dec_next.wsel  = width_code;
        dec_next.mask  = width_mask(width_code);
        dec_next.d     = dest_value & dec_next.mask;
        dec_next.s     = src_value & dec_next.mask;
        dec_next.cnt   = src_value[CntW-1:0];
        case (width_code)
            W_BYTE:  dec_next.rot = {2'b00, src_value[2:0]};
            W_WORD:  dec_next.rot = {1'b0, src_value[3:0]};
            default: dec_next.rot = src_value[CntW-1:0];
        endcase
        dec_next.cond  = cond_raw ^ cond_code[0];
        dec_next.flags = flags_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

// ===== rtl/lsu_exec.sv =====
// Second stage: logic operations, barrel shifts, rotate and setcc result.
module lsu_exec
    import lsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     dec_valid,
    input  lsu_dec_t dec,
    output logic     exe_valid,
    output lsu_exe_t exe
);

    logic             valid_reg;
    lsu_exe_t         exe_reg;
    lsu_exe_t         exe_next;
    logic [DataW-1:0] sar_ext;
    logic [BitsW-1:0] rot_back;

    always_comb
    begin
        sar_ext  = sign_bit(dec.d, dec.wsel) ? (dec.d | ~dec.mask) : dec.d;
        rot_back = width_bits(dec.wsel) - {1'b0, dec.rot};

        exe_next.r     = dec.d;
        exe_next.wb    = 1'b1;
        exe_next.setzs = 1'b0;
        exe_next.clrco = 1'b0;
        exe_next.wsel  = dec.wsel;
        exe_next.flags = dec.flags;

        case (lsu_cmd_t'(dec.cmd))
            CMD_AND:
            begin
                exe_next.r     = dec.d & dec.s;
                exe_next.setzs = 1'b1;
                exe_next.clrco = 1'b1;
            end
            CMD_OR:
            begin
                exe_next.r     = dec.d | dec.s;
                exe_next.setzs = 1'b1;
                exe_next.clrco = 1'b1;
            end
            CMD_XOR:
            begin
                exe_next.r     = dec.d ^ dec.s;
                exe_next.setzs = 1'b1;
                exe_next.clrco = 1'b1;
            end
            CMD_TEST:
            begin
                exe_next.r     = dec.d & dec.s;
                exe_next.setzs = 1'b1;
                exe_next.clrco = 1'b1;
                exe_next.wb    = 1'b0;
            end
            CMD_NOT:
            begin
                exe_next.r = ~dec.d & dec.mask;
            end
            CMD_SHL:
            begin
                exe_next.r     = (dec.d << dec.cnt) & dec.mask;
                exe_next.setzs = 1'b1;
            end
            CMD_SHR:
            begin
                exe_next.r     = dec.d >> dec.cnt;
                exe_next.setzs = 1'b1;
            end
            CMD_SAR:
            begin
                exe_next.r     = DataW'($signed(sar_ext) >>> dec.cnt) & dec.mask;
                exe_next.setzs = 1'b1;
            end
            CMD_ROL:
            begin
                // zero count: back shift equals width, drops to zero
                exe_next.r = ((dec.d << dec.rot) | (dec.d >> rot_back)) & dec.mask;
            end
            CMD_SETCC:
            begin
                exe_next.r = {{(DataW-1){1'b0}}, dec.cond};
            end
            default:
            begin
                exe_next.wb = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        exe_reg <= exe_next;
    end

    assign exe_valid = valid_reg;
    assign exe       = exe_reg;

endmodule

// ===== rtl/lsu_flags.sv =====
// Third stage: ZF/SF update, CF/OF clearing and the output register.
module lsu_flags
    import lsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             exe_valid,
    input  lsu_exe_t         exe,
    output logic             out_valid,
    output logic [DataW-1:0] out_result,
    output logic             out_wb,
    output lsu_flags_t       out_flags
);

    logic             valid_reg;
    logic [DataW-1:0] result_reg;
    logic             wb_reg;
    lsu_flags_t       flags_reg;
    lsu_flags_t       flags_next;

    always_comb
    begin
        flags_next = exe.flags;
        if (exe.setzs)
        begin
            flags_next.zf = (exe.r == '0);
            flags_next.sf = sign_bit(exe.r, exe.wsel);
        end
        if (exe.clrco)
        begin
            flags_next.cf = 1'b0;
            flags_next.of = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= exe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= exe.r;
        wb_reg     <= exe.wb;
        flags_reg  <= flags_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_wb     = wb_reg;
    assign out_flags  = flags_reg;

endmodule

// ===== rtl/x86_logic_shift_unit_top.sv =====
// Top level of the x86 logic and shift unit: three-stage pipeline.
// A taken request passes the decode, execute and flags stage registers in that order,
// and done is high with the result from the flags register. Throughput: one request
// per cycle, as busy is low from the first edge after reset release onwards.
// Results cannot be held off: done marks each result for exactly one cycle.
// Reset (rst_n, asynchronous, active low) empties the pipeline and holds busy high.
module x86_logic_shift_unit_top
    import lsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [3:0]       cmd,
    input  logic [1:0]       width_code,
    input  logic [DataW-1:0] dest_value,
    input  logic [DataW-1:0] src_value,
    input  logic [3:0]       cond_code,
    input  logic             carry_in,
    input  logic             zero_in,
    input  logic             sign_in,
    input  logic             overflow_in,
    input  logic             parity_in,
    output logic             done,
    output logic [DataW-1:0] result,
    output logic             write_back,
    output logic             carry_out,
    output logic             zero_out,
    output logic             sign_out,
    output logic             overflow_out
);

    logic       busy_reg;
    logic       busy_next;
    logic       req_take;
    lsu_flags_t flags_in;
    logic       dec_valid;
    lsu_dec_t   dec;
    logic       exe_valid;
    lsu_exe_t   exe;
    lsu_flags_t flags_out;

    assign busy_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign req_take = start & ~busy_reg;

    assign flags_in.cf = carry_in;
    assign flags_in.zf = zero_in;
    assign flags_in.sf = sign_in;
    assign flags_in.of = overflow_in;

    lsu_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_take),
        .cmd        (cmd),
        .width_code (width_code),
        .dest_value (dest_value),
        .src_value  (src_value),
        .cond_code  (cond_code),
        .flags_in   (flags_in),
        .parity_in  (parity_in),
        .dec_valid  (dec_valid),
        .dec        (dec)
    );

    lsu_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .exe_valid (exe_valid),
        .exe       (exe)
    );

    lsu_flags u_flags
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .exe_valid  (exe_valid),
        .exe        (exe),
        .out_valid  (done),
        .out_result (result),
        .out_wb     (write_back),
        .out_flags  (flags_out)
    );

    assign carry_out    = flags_out.cf;
    assign zero_out     = flags_out.zf;
    assign sign_out     = flags_out.sf;
    assign overflow_out = flags_out.of;

    a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_take, 3))
        else $error("done without a request three cycles earlier");

    a_no_wb_only_test: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_back) |-> ($past(cmd, 3) == 4'(CMD_TEST) || $past(cmd, 3) > 4'(CMD_SETCC)))
        else $error("write-back suppressed for a writing operation");

    a_setcc_bool: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd, 3) == 4'(CMD_SETCC)) |-> (result[DataW-1:1] == '0))
        else $error("setcc result not 0 or 1");

    a_logic_clr_co: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd, 3) == 4'(CMD_AND) || $past(cmd, 3) == 4'(CMD_OR)
            || $past(cmd, 3) == 4'(CMD_XOR) || $past(cmd, 3) == 4'(CMD_TEST)))
        |-> (!carry_out && !overflow_out))
        else $error("logic operation left CF or OF set");

endmodule
